/* rtl/sss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sss_pkg
// Shared codes and the cell control bundle of the segmented stack set.
// ----------------------------------------------------------------------------
package sss_pkg;

	localparam int POS_W = 6;

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_POP_AT = 2'd2;
	localparam logic [1:0] FUNC_TOP    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NO_STACK = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INC,
		CELL_NEW,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] last;
		logic             drop;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/sss_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sss_cell
// One list position: physical slot id and fill count, shifts down on drop.
// ----------------------------------------------------------------------------
module sss_cell import sss_pkg::*; #(
	parameter int IDX = 0,
	parameter int SW  = 4,
	parameter int FW  = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [SW-1:0] next_slot,
	input  wire logic [FW-1:0] next_fill,
	input  wire logic [SW-1:0] drop_slot,
	output logic      [SW-1:0] slot_q,
	output logic      [FW-1:0] fill_q
);

	logic [POS_W-1:0] me;
	logic             at_pos;

	assign me     = POS_W'(IDX);
	assign at_pos = (ctl.pos == me);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SW'(IDX);
			fill_q <= '0;
		end else begin
			case (ctl.op)
				CELL_INC: begin
					if (at_pos) fill_q <= fill_q + 1'b1;
				end
				CELL_NEW: begin
					if (at_pos) fill_q <= FW'(1);
				end
				CELL_REMOVE: begin
					if (ctl.drop) begin
						if (me >= ctl.pos && me < ctl.last) begin
							slot_q <= next_slot;
							fill_q <= next_fill;
						end else if (me == ctl.last) begin
							slot_q <= drop_slot;
							fill_q <= '0;
						end
					end else if (at_pos) begin
						fill_q <= fill_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/sss_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sss_store
// Element memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sss_store #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata_q
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/segmented_stack_set_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_stack_set_unit
// Ordered list of bounded sub-stacks: push, pop, pop at index, read top.
// ----------------------------------------------------------------------------
// One item at a time. The item is captured in the accept register, then an
// execute cycle updates the row of list cells. Push, pop and pop at index
// register their result at the end of the execute cycle. Top adds the
// registered read of the element memory, and its result is registered in
// the read state that follows. The input is ready again once the result is
// registered. A new item is taken while a result still waits; its execute
// cycle stalls until that result is taken.
module segmented_stack_set_unit import sss_pkg::*; #(
	parameter int MAX_STACKS   = 16,
	parameter int MAX_CAPACITY = 8,
	parameter int DATA_WIDTH   = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic        [3:0]  cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [1:0]  func,
	input  wire logic signed [31:0] push_value,
	input  wire logic        [3:0]  stack_index,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed      [31:0] top_value,
	output logic             [1:0]  status,
	output logic                    is_empty,
	output logic             [4:0]  stack_count
);

	localparam int SW    = $clog2(MAX_STACKS);
	localparam int FW    = $clog2(MAX_CAPACITY + 1);
	localparam int CW    = $clog2(MAX_STACKS + 1);
	localparam int DEPTH = MAX_STACKS * MAX_CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ} state_t;

	state_t          state_q;
	logic [3:0]      cfg_q;
	logic [1:0]      func_q;
	logic [31:0]     val_q;
	logic [3:0]      idx_q;
	logic [CW-1:0]   live_q;
	logic            out_valid_q;
	logic [31:0]     top_q;
	logic [1:0]      status_q;
	logic [CW-1:0]   count_q;

	logic [SW-1:0]   slot_w [MAX_STACKS];
	logic [FW-1:0]   fill_w [MAX_STACKS];
	cell_ctl_t       ctl;

	logic [FW-1:0]   eff_cap;
	logic [SW-1:0]   last_pos, tgt_pos, rm_pos, new_pos;
	logic [SW-1:0]   last_slot, rm_slot;
	logic [FW-1:0]   last_fill, rm_fill;
	logic            has_any, need_new, list_full, idx_ok, drop, can_out, go;
	logic            out_set;
	logic [1:0]      st_nx;
	logic [CW-1:0]   live_nx;
	logic            mem_we, mem_re;
	logic [AW-1:0]   waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;

	assign eff_cap = (cfg_q == 4'd0) ? FW'(1) :
		(8'(cfg_q) > 8'(MAX_CAPACITY)) ? FW'(MAX_CAPACITY) : FW'(cfg_q);

	assign has_any   = (live_q != '0);
	assign last_pos  = SW'(live_q - 1'b1);
	assign new_pos   = SW'(live_q);
	assign tgt_pos   = SW'(idx_q);
	assign last_slot = slot_w[last_pos];
	assign last_fill = fill_w[last_pos];
	assign need_new  = !has_any || (last_fill >= eff_cap);
	assign list_full = (live_q == CW'(MAX_STACKS));
	assign idx_ok    = (8'(idx_q) < 8'(live_q));
	assign rm_pos    = (func_q == FUNC_POP) ? last_pos : tgt_pos;
	assign rm_slot   = slot_w[rm_pos];
	assign rm_fill   = fill_w[rm_pos];
	assign drop      = (rm_fill <= FW'(1));
	assign can_out   = !out_valid_q || out_ready;
	assign go        = (state_q == S_EXEC) && can_out;
	assign wdata     = DATA_WIDTH'(val_q);
	assign out_set   = can_out && ((state_q == S_READ) || ((state_q == S_EXEC) &&
		!(func_q == FUNC_TOP && st_nx == ST_OK)));

	always_comb begin
		st_nx    = ST_OK;
		live_nx  = live_q;
		ctl.op   = CELL_HOLD;
		ctl.pos  = POS_W'(last_pos);
		ctl.last = POS_W'(last_pos);
		ctl.drop = drop;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		waddr    = AW'(last_slot) * AW'(MAX_CAPACITY) + AW'(last_fill);
		raddr    = AW'(last_slot) * AW'(MAX_CAPACITY) + AW'(last_fill) - 1'b1;
		case (func_q)
			FUNC_PUSH: begin
				if (need_new) begin
					if (list_full) begin
						st_nx = ST_FULL;
					end else begin
						live_nx = live_q + 1'b1;
						ctl.op  = CELL_NEW;
						ctl.pos = POS_W'(new_pos);
						mem_we  = 1'b1;
						waddr   = AW'(slot_w[new_pos]) * AW'(MAX_CAPACITY);
					end
				end else begin
					ctl.op = CELL_INC;
					mem_we = 1'b1;
				end
			end
			FUNC_POP, FUNC_POP_AT: begin
				if (func_q == FUNC_POP && !has_any) begin
					st_nx = ST_EMPTY;
				end else if (func_q == FUNC_POP_AT && !idx_ok) begin
					st_nx = ST_NO_STACK;
				end else begin
					ctl.op  = CELL_REMOVE;
					ctl.pos = POS_W'(rm_pos);
					if (drop) live_nx = live_q - 1'b1;
				end
			end
			default: begin
				if (!has_any) st_nx = ST_EMPTY;
				else mem_re = 1'b1;
			end
		endcase
		if (!go) begin
			ctl.op = CELL_HOLD;
			mem_we = 1'b0;
			mem_re = 1'b0;
		end
	end

	for (genvar i = 0; i < MAX_STACKS; i++) begin : g_cell
		localparam int NXT = (i + 1 < MAX_STACKS) ? i + 1 : i;
		sss_cell #(.IDX(i), .SW(SW), .FW(FW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.next_slot (slot_w[NXT]),
			.next_fill (fill_w[NXT]),
			.drop_slot (rm_slot),
			.slot_q    (slot_w[i]),
			.fill_q    (fill_w[i])
		);
	end

	sss_store #(.DEPTH(DEPTH), .AW(AW), .DW(DATA_WIDTH)) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (mem_re),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= 4'd3;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (out_set) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						val_q   <= push_value;
						idx_q   <= stack_index;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (can_out) begin
						live_q <= live_nx;
						if (func_q == FUNC_TOP && st_nx == ST_OK) begin
							state_q <= S_READ;
						end else begin
							top_q       <= '0;
							status_q    <= st_nx;
							count_q     <= live_nx;
							state_q     <= S_IDLE;
						end
					end
				end
				S_READ: begin
					if (can_out) begin
						top_q       <= 32'(rdata);
						status_q    <= ST_OK;
						count_q     <= live_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign top_value   = $signed(top_q);
	assign status      = status_q;
	assign is_empty    = (count_q == '0);
	assign stack_count = 5'(count_q);

endmodule
`default_nettype wire

/* rtl/sss_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks of the segmented stack set, bound to the top level.
// ----------------------------------------------------------------------------
module sss_checker import sss_pkg::*; #(
	parameter int MAX_STACKS = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] top_value,
	input wire logic [1:0]  status,
	input wire logic        is_empty,
	input wire logic [4:0]  stack_count
);

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (stack_count == 5'd0)))
		else $error("is_empty disagrees with stack_count");

	a_err_no_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (top_value == 32'd0))
		else $error("nonzero top_value on error");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (stack_count == 5'(MAX_STACKS)))
		else $error("list full reported below capacity");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> is_empty)
		else $error("empty status with sub-stacks present");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(top_value)
			&& $stable(status) && $stable(stack_count)))
		else $error("stalled item changed");

endmodule

bind segmented_stack_set_unit sss_checker #(.MAX_STACKS(MAX_STACKS)) u_sss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.top_value   (top_value),
	.status      (status),
	.is_empty    (is_empty),
	.stack_count (stack_count)
);
`default_nettype wire
